/* sv/pafire_pkg.sv */
`timescale 1ns / 1ps

package pafire_pkg;

  localparam int CODE_W    = 10;
  localparam int DELAY_W   = 16;
  localparam int PULSE_W   = 8;
  localparam int PROD_W    = CODE_W + DELAY_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 1'd1;

  localparam logic [DELAY_W-1:0] FULL_SCALE_RST  = 16'd8300;
  localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 8'd20;
  localparam logic [CODE_W:0]    CODE_MAX        = 11'd1023;

endpackage

/* sv/phase_angle_firing_timer_top.sv */
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata: zero_cross_edge, sample_code; tuser: sample_valid
// out_    | out | out_tvalid/out_tready | tdata: gate, delay_now
// cfg_    | in  | cfg_we              | cfg_index, cfg_wdata
//
// One request per clock sustained while out_tready is high; results leave the result register.
// Stages: input register, 10x16 product register, result register holding the timer state.
// Division by 1023 is two short folding adds and one compare in the last stage.
// rst_n is synchronous, active low; the first request after reset matches and fires.
// A stalled result holds the pipe only once every stage is full.

module phase_angle_firing_timer_top
  import pafire_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] zero_cross_edge, [10:1] sample_code
  input  logic                  in_tuser,   // [0] sample_valid
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] gate, [16:1] delay_now
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DELAY_W-1:0] full_scale_r;
  logic [PULSE_W-1:0] pulse_ticks_r;

  logic               s1_vld_r;
  logic               s1_edge_r;
  logic               s1_svld_r;
  logic [CODE_W-1:0]  s1_code_r;

  logic               s2_vld_r;
  logic               s2_edge_r;
  logic               s2_svld_r;
  logic [PROD_W-1:0]  s2_prod_r;

  logic               out_vld_r;
  logic               gate_r;
  logic [DELAY_W-1:0] tick_r;
  logic [DELAY_W-1:0] delay_r;
  logic [DELAY_W-1:0] target_r;
  logic [PULSE_W-1:0] pulse_left_r;

  logic               out_free;
  logic               adv3;
  logic               s2_ready;
  logic               adv2;
  logic               adv1;

  logic [DELAY_W-1:0] quo_a;
  logic [DELAY_W:0]   quo_s;
  logic [CODE_W:0]    quo_t;
  logic               quo_corr;
  logic [DELAY_W-1:0] quo;

  logic               match;
  logic [PULSE_W-1:0] pulse_load;
  logic               gate_nxt;
  logic [DELAY_W-1:0] delay_nxt;
  logic [DELAY_W-1:0] target_nxt;
  logic [PULSE_W-1:0] pulse_left_nxt;

  assign out_free  = !out_vld_r || out_tready;
  assign adv3      = s2_vld_r && out_free;
  assign s2_ready  = !s2_vld_r || out_free;
  assign adv2      = s1_vld_r && s2_ready;
  assign in_tready = !s1_vld_r || s2_ready;
  assign adv1      = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - DELAY_W - 1){1'b0}}, delay_r, gate_r};

  // p = 1024a + b = 1023a + (a + b); fold once more, then one compare
  assign quo_a    = s2_prod_r[PROD_W-1:CODE_W];
  assign quo_s    = {1'b0, quo_a} + {{(DELAY_W + 1 - CODE_W){1'b0}}, s2_prod_r[CODE_W-1:0]};
  assign quo_t    = {{(CODE_W + 1 - (DELAY_W + 1 - CODE_W)){1'b0}}, quo_s[DELAY_W:CODE_W]}
                  + {1'b0, quo_s[CODE_W-1:0]};
  assign quo_corr = quo_t >= CODE_MAX;
  assign quo      = quo_a + {{(CODE_W - 1){1'b0}}, quo_s[DELAY_W:CODE_W]}
                  + {{(DELAY_W - 1){1'b0}}, quo_corr};

  always_comb begin
    delay_nxt      = s2_svld_r ? quo : delay_r;
    match          = tick_r == target_r;
    target_nxt     = s2_edge_r ? tick_r + delay_nxt : target_r;
    pulse_load     = match ? pulse_ticks_r : pulse_left_r;
    gate_nxt       = pulse_load != '0;
    pulse_left_nxt = gate_nxt ? pulse_load - 1'b1 : pulse_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r  <= FULL_SCALE_RST;
      pulse_ticks_r <= PULSE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_SCALE:  full_scale_r  <= cfg_wdata[DELAY_W-1:0];
        CFG_PULSE_TICKS: pulse_ticks_r <= cfg_wdata[PULSE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      gate_r       <= 1'b0;
      tick_r       <= '0;
      delay_r      <= '0;
      target_r     <= '0;
      pulse_left_r <= '0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_vld_r <= s1_vld_r;
      end
      if (out_free) begin
        out_vld_r <= s2_vld_r;
      end
      if (adv3) begin
        gate_r       <= gate_nxt;
        tick_r       <= tick_r + 1'b1;
        delay_r      <= delay_nxt;
        target_r     <= target_nxt;
        pulse_left_r <= pulse_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_edge_r <= in_tdata[0];
      s1_svld_r <= in_tuser;
      s1_code_r <= in_tdata[CODE_W:1];
    end
    if (adv2) begin
      s2_edge_r <= s1_edge_r;
      s2_svld_r <= s1_svld_r;
      s2_prod_r <= {{DELAY_W{1'b0}}, s1_code_r} * {{CODE_W{1'b0}}, full_scale_r};
    end
  end

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv3 |=> tick_r == $past(tick_r) + 1'b1)
    else $error("tick counter did not advance with the request");

  a_no_stray_gate: assert property (@(posedge clk) disable iff (!rst_n)
    adv3 && !match && pulse_left_r == '0 |=> !gate_r)
    else $error("gate raised without a match or a pulse in progress");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_vld_r && s2_vld_r && out_vld_r && !out_tready)
    else $error("input stalled while the pipe has room");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !adv3 |=> $stable(tick_r) && $stable(target_r) && $stable(pulse_left_r))
    else $error("timer state changed without a request");

endmodule

/* bench/phase_angle_firing_timer_top_test.sv */
`timescale 1ns / 1ps

module phase_angle_firing_timer_top_test;
  import pafire_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int LONG_HOLD      = 300;

  typedef struct packed {
    logic              zc;
    logic              sample_valid;
    logic [CODE_W-1:0] code;
  } tick_t;

  typedef struct packed {
    logic               gate;
    logic [DELAY_W-1:0] delay_now;
  } firing_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [0] zero_cross_edge, [10:1] sample_code
  logic                  in_tuser = 1'b0;  // [0] sample_valid
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [0] gate, [16:1] delay_now
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  phase_angle_firing_timer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // timer model state
  logic [DELAY_W-1:0] full_scale = FULL_SCALE_RST;
  logic [PULSE_W-1:0] pulse_len  = PULSE_TICKS_RST;
  logic [DELAY_W-1:0] tick_ctr   = '0;
  logic [DELAY_W-1:0] delay_reg  = '0;
  logic [DELAY_W-1:0] target_reg = '0;
  logic [PULSE_W-1:0] owed_ticks = '0;

  tick_t   tick_q[$];
  firing_t firing_q[$];
  tick_t   offered;

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int rx_hold = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int gate_highs = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic firing_t advance_tick(tick_t t);
    firing_t r;
    logic [PROD_W-1:0] prod;
    logic hit;
    if (t.sample_valid) begin
      prod = t.code * full_scale;
      delay_reg = DELAY_W'(prod / CODE_MAX);
    end
    hit = (tick_ctr == target_reg);
    if (t.zc) target_reg = tick_ctr + delay_reg;
    if (hit) owed_ticks = pulse_len;
    r.gate = (owed_ticks != '0);
    if (r.gate) owed_ticks = owed_ticks - 1'b1;
    r.delay_now = delay_reg;
    tick_ctr = tick_ctr + 1'b1;
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {CODE_W{1'b1}};
      default: return CODE_W'($urandom);
    endcase
  endfunction

  task automatic push_tick(logic zc, logic sv, logic [CODE_W-1:0] code);
    tick_t t;
    t.zc = zc;
    t.sample_valid = sv;
    t.code = code;
    tick_q.push_back(t);
  endtask

  // periodic zero crossings with sample updates, plus stray edges
  task automatic queue_mains(int n, int period);
    for (int i = 0; i < n; i++)
      push_tick((i % period == period - 1) || ($urandom_range(0, 19) == 0),
                $urandom_range(0, 5) == 0, pick_code());
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_tvalid || firing_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_FULL_SCALE) full_scale = data;
    else if (idx == CFG_PULSE_TICKS) pulse_len = data[PULSE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timer(logic [DELAY_W-1:0] fs, logic [PULSE_W-1:0] pw);
    write_reg(CFG_FULL_SCALE, fs);
    write_reg(CFG_PULSE_TICKS, {8'($urandom), pw});
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        firing_q.push_back(advance_tick(offered));
        ticks_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          offered = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_DATA_W'({offered.code, offered.zc});
          in_tuser <= offered.sample_valid;
          send_gap = send_idle ? $urandom_range(0, 4) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    firing_t got;
    firing_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.gate = out_tdata[0];
        got.delay_now = out_tdata[16:1];
        results_seen++;
        if (got.gate === 1'b1) gate_highs++;
        if (firing_q.size() == 0) begin
          if (fail_count < 10)
            $display("result %0d with no request outstanding: gate=%b delay_now=%0d",
                     results_seen, got.gate, got.delay_now);
          fail_count++;
        end else begin
          want = firing_q.pop_front();
          if (got.gate !== want.gate || got.delay_now !== want.delay_now) begin
            if (fail_count < 10)
              $display("result %0d: expected gate=%b delay_now=%0d, got gate=%b delay_now=%0d",
                       results_seen, want.gate, want.delay_now, got.gate, got.delay_now);
            fail_count++;
          end
        end
        if (recv_idle) recv_gap = $urandom_range(0, 4);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("phase_angle_firing_timer_top_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 1'b1;
    recv_idle = 1'b1;
    push_tick(1'b0, 1'b0, '0);
    push_tick(1'b0, 1'b1, 10'd1023);
    push_tick(1'b0, 1'b1, 10'd0);
    push_tick(1'b0, 1'b1, 10'd1);
    push_tick(1'b0, 1'b1, 10'd1022);
    push_tick(1'b0, 1'b1, 10'd2);
    push_tick(1'b1, 1'b0, 10'd1023);
    push_tick(1'b1, 1'b1, 10'd1);
    for (int i = 0; i < 15; i++) push_tick(1'b0, 1'b0, '0);
    push_tick(1'b0, 1'b1, 10'h2AA);
    push_tick(1'b1, 1'b1, 10'h155);
    drain();

    set_timer(16'd30, 8'd3);
    queue_mains(200, 40);
    drain();

    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_timer(16'd10, 8'd255);
    queue_mains(120, 25);
    drain();

    // zero pulse length: a match cuts any pulse still running
    send_idle = 1'b1;
    set_timer(16'd10, 8'd0);
    queue_mains(100, 20);
    drain();

    recv_idle = 1'b1;
    set_timer(16'hFFFF, 8'd255);
    push_tick(1'b1, 1'b1, 10'd1023);
    queue_mains(100, 30);
    rx_hold = LONG_HOLD;
    drain();

    set_timer(16'd0, 8'd1);
    queue_mains(75, 35);
    drain();
    queue_mains(75, 35);
    drain();

    send_idle = 1'($urandom_range(0, 1));
    set_timer(16'd100, 8'($urandom_range(1, 255)));
    queue_mains(200, 60);
    drain();

    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_timer(16'd200, 8'd7);
    queue_mains(55, 12);
    drain();

    $display("%0d ticks checked over eight timer settings, full-scale 0..65535, pulse 0..255",
             results_seen);
    $display("%0d gate-high ticks among %0d requests, with stalls and one long output hold",
             gate_highs, ticks_sent);
    if (fail_count == 0 && firing_q.size() == 0) begin
      $display("phase_angle_firing_timer_top_test: PASS");
    end else begin
      $display("phase_angle_firing_timer_top_test: FAIL");
    end
    $finish;
  end

endmodule
